// ===== design/mch_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mch_pkg
// Shared types, constants and the arctangent table for the compass heading
// core.
// ----------------------------------------------------------------------------
package mch_pkg;

  // Burst layout and algorithm sizing
  localparam int BURST_BYTES       = 6;
  localparam int CORDIC_STEPS      = 16;
  localparam int HEADING_FRAC_BITS = 7;
  localparam int ANG_FRAC          = 16;

  // Datapath widths
  localparam int CNT_W   = 3;
  localparam int RAWX_W  = 16;
  localparam int RAWY_W  = 17;
  localparam int DIFF_W  = 18;
  localparam int PROD_W  = 35;
  localparam int CAL_W   = 18;
  localparam int CAL_FRAC = 14;
  localparam int SHR_W   = PROD_W - CAL_FRAC;
  localparam int XY_W    = 21;
  localparam int Z_W     = 27;
  localparam int ATAN_W  = 22;
  localparam int ITER_W  = $clog2(CORDIC_STEPS);
  localparam int HEAD_W  = 16;

  localparam logic signed [CAL_W-1:0] CAL_MAX = 18'sd131071;
  localparam logic signed [CAL_W-1:0] CAL_MIN = -18'sd131072;

  localparam logic signed [Z_W-1:0] Z_QUARTER = Z_W'(90 << ANG_FRAC);
  localparam logic signed [Z_W-1:0] Z_HALF    = Z_W'(180 << ANG_FRAC);
  localparam int HEAD_SHIFT = ANG_FRAC - HEADING_FRAC_BITS;
  localparam logic signed [Z_W-1:0] HEAD_ROUND = Z_W'(1 << (HEAD_SHIFT - 1));
  localparam logic signed [Z_W-1:0] HEAD_FULL  = Z_W'(360 << HEADING_FRAC_BITS);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_BIAS_X  = 2'd0,
    REG_BIAS_Y  = 2'd1,
    REG_SCALE_X = 2'd2,
    REG_SCALE_Y = 2'd3
  } cfg_reg_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_SAT_Y,
    ST_PRE,
    ST_ITER,
    ST_FIN
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic mul_x;
    logic mul_y;
    logic sat_y;
    logic pre;
    logic iter;
    logic load;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic iter_last;
  } status_t;

  // atan(2^-i) in 2^-16 degree
  function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] i);
    logic [ATAN_W-1:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/magnetometer_compass_heading_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_compass_heading_core
// Compass heading from a magnetometer read burst, with bias and scale
// calibration and an iterative CORDIC arctangent.
// ----------------------------------------------------------------------------
// Usage:
//   Byte channel (byte_valid / byte_stall, data_byte, end_of_burst) takes the
//   read-data bytes of a sensor burst, one transaction per byte. A byte that
//   is not the last of a burst is taken without a stall in idle and gives no result.
//   The last byte of a burst starts a computation: the X and Y products in the
//   shared multiplier, a saturation step for Y, a pre-rotation step, CORDIC_STEPS
//   (16) CORDIC iterations and a final step that loads the result. byte_stall
//   stays high until the block is back in idle.
//   Result channel (result_valid / result_stall) carries heading, fresh and
//   the calibrated axes from an output register; bytes of the next burst are
//   taken while a result waits. If the previous result is still stalled when
//   a new one is ready, the block holds in its final state until it leaves.
//   Configuration: cfg_write with cfg_index and cfg_data, idle only.
//   Reset (synchronous, rst high) clears the byte count, the raw sample and
//   result_valid and restores unity scale and zero bias.
// ----------------------------------------------------------------------------
module magnetometer_compass_heading_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [1:0]                         cfg_index,
  input  logic [15:0]                        cfg_data,
  input  logic                               byte_valid,
  output logic                               byte_stall,
  input  logic [7:0]                         data_byte,
  input  logic                               end_of_burst,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [mch_pkg::HEAD_W-1:0]         heading,
  output logic                               fresh,
  output logic signed [mch_pkg::CAL_W-1:0]   calibrated_x,
  output logic signed [mch_pkg::CAL_W-1:0]   calibrated_y
);

  mch_pkg::cmd_t    cmd;
  mch_pkg::status_t status;

  // Sequencer
  mch_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .end_of_burst (end_of_burst),
    .byte_stall   (byte_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Arithmetic and storage
  mch_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .end_of_burst (end_of_burst),
    .cmd          (cmd),
    .status       (status),
    .heading      (heading),
    .fresh        (fresh),
    .calibrated_x (calibrated_x),
    .calibrated_y (calibrated_y)
  );

endmodule

// ===== design/mch_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mch_ctrl
// Sequencer: takes burst bytes, steps the calibration multiplier and the
// CORDIC iterations, and owns the result valid flag.
// ----------------------------------------------------------------------------
module mch_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  input  logic              end_of_burst,
  output logic              byte_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  mch_pkg::status_t  status,
  output mch_pkg::cmd_t     cmd
);

  mch_pkg::state_t state;
  mch_pkg::state_t state_next;
  logic            result_valid_next;
  logic            accept;
  logic            out_free;

  assign accept   = byte_valid && !byte_stall;
  assign out_free = !result_valid || !result_stall;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mch_pkg::ST_IDLE:  if (accept && end_of_burst) state_next = mch_pkg::ST_MUL_X;
      mch_pkg::ST_MUL_X: state_next = mch_pkg::ST_MUL_Y;
      mch_pkg::ST_MUL_Y: state_next = mch_pkg::ST_SAT_Y;
      mch_pkg::ST_SAT_Y: state_next = mch_pkg::ST_PRE;
      mch_pkg::ST_PRE:   state_next = mch_pkg::ST_ITER;
      mch_pkg::ST_ITER:  if (status.iter_last) state_next = mch_pkg::ST_FIN;
      mch_pkg::ST_FIN:   if (out_free) state_next = mch_pkg::ST_IDLE;
      default:           state_next = mch_pkg::ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd        = '0;
    byte_stall = 1'b1;
    case (state)
      mch_pkg::ST_IDLE: begin
        byte_stall  = 1'b0;
        cmd.capture = accept;
      end
      mch_pkg::ST_MUL_X: cmd.mul_x = 1'b1;
      mch_pkg::ST_MUL_Y: cmd.mul_y = 1'b1;
      mch_pkg::ST_SAT_Y: cmd.sat_y = 1'b1;
      mch_pkg::ST_PRE:   cmd.pre   = 1'b1;
      mch_pkg::ST_ITER:  cmd.iter  = 1'b1;
      mch_pkg::ST_FIN:   cmd.load  = out_free;
      default:           cmd       = '0;
    endcase
  end

  // Result valid: set on load, drop when the transaction completes
  always_comb begin
    result_valid_next = result_valid;
    if (cmd.load) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= mch_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // Checks
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> result_valid)
    else $error("result not presented after load");

  a_burst_start: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_burst) |=> (state == mch_pkg::ST_MUL_X))
    else $error("burst end did not start calibration");

  a_iter_hold: assert property (@(posedge clk) disable iff (rst)
    (state == mch_pkg::ST_ITER && !status.iter_last) |=> (state == mch_pkg::ST_ITER))
    else $error("CORDIC left early");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one command at once");

endmodule

// ===== design/mch_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mch_dp
// Datapath: byte store, raw sample, configuration registers, shared
// calibration multiplier, iterative CORDIC and the result register.
// ----------------------------------------------------------------------------
module mch_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [1:0]                             cfg_index,
  input  logic [15:0]                            cfg_data,
  input  logic [7:0]                             data_byte,
  input  logic                                   end_of_burst,
  input  mch_pkg::cmd_t                          cmd,
  output mch_pkg::status_t                       status,
  output logic [mch_pkg::HEAD_W-1:0]             heading,
  output logic                                   fresh,
  output logic signed [mch_pkg::CAL_W-1:0]       calibrated_x,
  output logic signed [mch_pkg::CAL_W-1:0]       calibrated_y
);

  logic [mch_pkg::CNT_W-1:0]          byte_count;
  logic [7:0]                         byte_store [mch_pkg::BURST_BYTES];
  logic signed [mch_pkg::RAWX_W-1:0]  raw_x;
  logic signed [mch_pkg::RAWY_W-1:0]  raw_y;
  logic                               burst_fresh;
  logic signed [15:0]                 bias_x;
  logic signed [15:0]                 bias_y;
  logic [15:0]                        scale_x;
  logic [15:0]                        scale_y;

  logic signed [mch_pkg::DIFF_W-1:0]  diff_sel;
  logic [15:0]                        scale_sel;
  logic signed [mch_pkg::PROD_W-1:0]  prod;
  logic signed [mch_pkg::SHR_W-1:0]   prod_shr;
  logic signed [mch_pkg::CAL_W-1:0]   prod_sat;
  logic signed [mch_pkg::CAL_W-1:0]   cx;
  logic signed [mch_pkg::CAL_W-1:0]   cy;

  logic signed [mch_pkg::XY_W-1:0]    cx_ext;
  logic signed [mch_pkg::XY_W-1:0]    cy_ext;
  logic signed [mch_pkg::XY_W-1:0]    x;
  logic signed [mch_pkg::XY_W-1:0]    y;
  logic signed [mch_pkg::Z_W-1:0]     z;
  logic                               both_zero;
  logic [mch_pkg::ITER_W-1:0]         iter;
  logic signed [mch_pkg::XY_W-1:0]    dx;
  logic signed [mch_pkg::XY_W-1:0]    dy;
  logic signed [mch_pkg::Z_W-1:0]     dz;

  logic signed [mch_pkg::Z_W-1:0]     h_sum;
  logic signed [mch_pkg::Z_W-1:0]     h_pos;
  logic signed [mch_pkg::Z_W-1:0]     h_rnd;
  logic signed [mch_pkg::Z_W-1:0]     h_fin;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bias_x  <= 16'sd0;
      bias_y  <= 16'sd0;
      scale_x <= 16'd16384;
      scale_y <= 16'd16384;
    end else if (cfg_write) begin
      case (cfg_index)
        mch_pkg::REG_BIAS_X:  bias_x  <= cfg_data;
        mch_pkg::REG_BIAS_Y:  bias_y  <= cfg_data;
        mch_pkg::REG_SCALE_X: scale_x <= cfg_data;
        mch_pkg::REG_SCALE_Y: scale_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte capture: store the first six bytes, saturate the count
  always_ff @(posedge clk) begin
    if (cmd.capture && byte_count < mch_pkg::CNT_W'(mch_pkg::BURST_BYTES)) begin
      byte_store[byte_count] <= data_byte;
    end
  end

  // Count and raw sample; a six-byte burst updates the sample
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      raw_x       <= '0;
      raw_y       <= '0;
      burst_fresh <= 1'b0;
    end else if (cmd.capture) begin
      if (end_of_burst) begin
        byte_count  <= '0;
        burst_fresh <= (byte_count == mch_pkg::CNT_W'(mch_pkg::BURST_BYTES - 1));
        if (byte_count == mch_pkg::CNT_W'(mch_pkg::BURST_BYTES - 1)) begin
          raw_x <= {byte_store[0], byte_store[1]};
          raw_y <= -(mch_pkg::RAWY_W'($signed({byte_store[4], data_byte})));
        end
      end else if (byte_count != '1) begin
        byte_count <= byte_count + 1'b1;
      end
    end
  end

  // Shared multiplier: subtract bias, scale
  always_comb begin
    if (cmd.mul_y) begin
      diff_sel  = mch_pkg::DIFF_W'(raw_y) - mch_pkg::DIFF_W'(bias_y);
      scale_sel = scale_y;
    end else begin
      diff_sel  = mch_pkg::DIFF_W'(raw_x) - mch_pkg::DIFF_W'(bias_x);
      scale_sel = scale_x;
    end
  end

  // Floor shift and saturate the registered product
  always_comb begin
    prod_shr = prod[mch_pkg::PROD_W-1:mch_pkg::CAL_FRAC];
    if (prod_shr > mch_pkg::SHR_W'(mch_pkg::CAL_MAX)) begin
      prod_sat = mch_pkg::CAL_MAX;
    end else if (prod_shr < mch_pkg::SHR_W'(mch_pkg::CAL_MIN)) begin
      prod_sat = mch_pkg::CAL_MIN;
    end else begin
      prod_sat = prod_shr[mch_pkg::CAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_x || cmd.mul_y) begin
      prod <= mch_pkg::PROD_W'(diff_sel) * $signed({19'd0, scale_sel});
    end
    if (cmd.mul_y) begin
      cx <= prod_sat;
    end
    if (cmd.sat_y) begin
      cy <= prod_sat;
    end
  end

  // CORDIC micro-rotation terms
  assign cx_ext = mch_pkg::XY_W'(cx);
  assign cy_ext = mch_pkg::XY_W'(cy);
  assign dx     = y >>> iter;
  assign dy     = x >>> iter;
  assign dz     = $signed({5'd0, mch_pkg::atan_entry(5'(iter))});
  assign status.iter_last = (iter == mch_pkg::ITER_W'(mch_pkg::CORDIC_STEPS - 1));

  // Pre-rotate into the right half plane, then iterate
  always_ff @(posedge clk) begin
    if (cmd.pre) begin
      iter      <= '0;
      both_zero <= (cx == '0) && (cy == '0);
      if (cx < 0) begin
        if (cy >= 0) begin
          x <= cy_ext;
          y <= -cx_ext;
          z <= mch_pkg::Z_QUARTER;
        end else begin
          x <= -cy_ext;
          y <= cx_ext;
          z <= -mch_pkg::Z_QUARTER;
        end
      end else begin
        x <= cx_ext;
        y <= cy_ext;
        z <= '0;
      end
    end else if (cmd.iter) begin
      iter <= iter + 1'b1;
      if (y > 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + dz;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - dz;
      end
    end
  end

  // Offset by half a turn, round half up, clamp
  always_comb begin
    h_sum = both_zero ? mch_pkg::Z_HALF : (z + mch_pkg::Z_HALF);
    h_pos = (h_sum < 0) ? '0 : h_sum;
    h_rnd = (h_pos + mch_pkg::HEAD_ROUND) >>> mch_pkg::HEAD_SHIFT;
    h_fin = (h_rnd > mch_pkg::HEAD_FULL) ? mch_pkg::HEAD_FULL : h_rnd;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      heading      <= h_fin[mch_pkg::HEAD_W-1:0];
      fresh        <= burst_fresh;
      calibrated_x <= cx;
      calibrated_y <= cy;
    end
  end

endmodule

// ===== sim/mch_heading_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mch_heading_checker
// Watches the byte, result and register ports of the compass heading core,
// predicts every compass fix from the accepted bytes and compares each result
// transaction with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module mch_heading_checker
  import mch_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [1:0]               cfg_index,
  input  logic [15:0]              cfg_data,
  input  logic                     byte_valid,
  input  logic                     byte_stall,
  input  logic [7:0]               data_byte,
  input  logic                     end_of_burst,
  input  logic                     result_valid,
  input  logic                     result_stall,
  input  logic [HEAD_W-1:0]        heading,
  input  logic                     fresh,
  input  logic signed [CAL_W-1:0]  calibrated_x,
  input  logic signed [CAL_W-1:0]  calibrated_y,
  output int                       failures,
  output int                       waiting,
  output int                       checked
);

  // One predicted compass fix
  typedef struct packed {
    logic [HEAD_W-1:0]       heading;
    logic                    fresh;
    logic signed [CAL_W-1:0] cal_x;
    logic signed [CAL_W-1:0] cal_y;
  } compass_fix_t;

  // Arctangent of 2^-i in 2^-16 degree
  localparam longint ARCTAN_STEP [0:23] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };

  compass_fix_t fix_q[$];

  // Shadow of the core's sample and calibration registers
  logic [2:0]  fill;
  logic [7:0]  burst_buf [BURST_BYTES];
  longint      sample_x;
  longint      sample_y;
  logic [15:0] offset_x;
  logic [15:0] offset_y;
  logic [15:0] gain_x;
  logic [15:0] gain_y;

  // Remove bias, apply Q2.14 gain with a floor shift, saturate to 18 bits
  function automatic longint correct_axis(longint raw, logic [15:0] bias,
                                          logic [15:0] gain);
    longint p;
    p = (raw - longint'($signed(bias))) * longint'(gain);
    p = p >>> CAL_FRAC;
    if (p > 131071) p = 131071;
    if (p < -131072) p = -131072;
    return p;
  endfunction

  // Vectoring rotation: angle of (x, y) in 2^-16 degree
  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    // fold the left half plane onto the right one
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = longint'(90) << ANG_FRAC;
      end else begin
        t = x; x = -y; y = t; z = -(longint'(90) << ANG_FRAC);
      end
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ARCTAN_STEP[i];
      end else begin
        x -= dx; y += dy; z -= ARCTAN_STEP[i];
      end
    end
    return z;
  endfunction

  // Take one accepted byte; predict a fix at the end of the burst
  task automatic take_byte(logic [7:0] b, logic last);
    compass_fix_t fix;
    longint cx;
    longint cy;
    longint h;
    longint full;
    if (fill < BURST_BYTES) burst_buf[fill] = b;
    if (fill < 3'd7) fill++;
    if (last) begin
      fix.fresh = (fill == BURST_BYTES);
      if (fix.fresh) begin
        sample_x = longint'($signed({burst_buf[0], burst_buf[1]}));
        sample_y = -longint'($signed({burst_buf[4], burst_buf[5]}));
      end
      fill = '0;
      cx = correct_axis(sample_x, offset_x, gain_x);
      cy = correct_axis(sample_y, offset_y, gain_y);
      h = vector_angle(cy, cx) + (longint'(180) << ANG_FRAC);
      if (h < 0) h = 0;
      h = (h + (longint'(1) << (ANG_FRAC - 1 - HEADING_FRAC_BITS)))
          >>> (ANG_FRAC - HEADING_FRAC_BITS);
      full = longint'(360) << HEADING_FRAC_BITS;
      if (h > full) h = full;
      fix.heading = h[HEAD_W-1:0];
      fix.cal_x   = cx[CAL_W-1:0];
      fix.cal_y   = cy[CAL_W-1:0];
      fix_q.push_back(fix);
    end
  endtask

  task automatic flag(string what, longint want, longint got);
    failures++;
    $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
  endtask

  // Track every transaction on the rising edge
  always @(posedge clk) begin
    compass_fix_t want;
    if (rst) begin
      fill     = '0;
      sample_x = 0;
      sample_y = 0;
      offset_x = '0;
      offset_y = '0;
      gain_x   = 16'd16384;
      gain_y   = 16'd16384;
      for (int k = 0; k < BURST_BYTES; k++) burst_buf[k] = '0;
      fix_q.delete();
      failures = 0;
      checked  = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_BIAS_X:  offset_x = cfg_data;
          REG_BIAS_Y:  offset_y = cfg_data;
          REG_SCALE_X: gain_x   = cfg_data;
          REG_SCALE_Y: gain_y   = cfg_data;
          default: ;
        endcase
      end
      // compare before predicting: a fix never leaves in its own byte's cycle
      if (result_valid && !result_stall) begin
        if (fix_q.size() == 0) begin
          failures++;
          $display("%0t: unexpected result: expected none, got heading %0d fresh %0d",
                   $time, heading, fresh);
        end else begin
          want = fix_q.pop_front();
          checked++;
          if (heading !== want.heading) flag("heading", want.heading, heading);
          if (fresh !== want.fresh) flag("fresh", want.fresh, fresh);
          if (calibrated_x !== want.cal_x) flag("calibrated_x", want.cal_x, calibrated_x);
          if (calibrated_y !== want.cal_y) flag("calibrated_y", want.cal_y, calibrated_y);
        end
      end
      if (byte_valid && !byte_stall) take_byte(data_byte, end_of_burst);
    end
    waiting = fix_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives sensor read bursts and calibration settings into the compass
// heading core, with random gaps on both channels, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
  import mch_pkg::*;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic byte_valid;
  logic byte_stall;
  logic [7:0] data_byte;
  logic end_of_burst;
  logic result_valid;
  logic result_stall;
  logic [HEAD_W-1:0] heading;
  logic fresh;
  logic signed [CAL_W-1:0] calibrated_x;
  logic signed [CAL_W-1:0] calibrated_y;

  int failures;
  int waiting;
  int checked;
  int bytes_sent;
  int bursts_sent;
  int settings_used;
  bit steady;

  magnetometer_compass_heading_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .end_of_burst (end_of_burst),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .heading      (heading),
    .fresh        (fresh),
    .calibrated_x (calibrated_x),
    .calibrated_y (calibrated_y)
  );

  mch_heading_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .end_of_burst (end_of_burst),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .heading      (heading),
    .fresh        (fresh),
    .calibrated_x (calibrated_x),
    .calibrated_y (calibrated_y),
    .failures     (failures),
    .waiting      (waiting),
    .checked      (checked)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Send one byte transaction after a random gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    repeat (gap) begin
      @(negedge clk);
      byte_valid <= 1'b0;
    end
    @(negedge clk);
    byte_valid   <= 1'b1;
    data_byte    <= b;
    end_of_burst <= last;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
  endtask

  // Six-byte burst given as X, Z, Y words, most significant byte first
  task automatic send_six(input logic [47:0] words);
    for (int k = 0; k < 6; k++) send_byte(words[47 - 8*k -: 8], k == 5);
    bursts_sent++;
  endtask

  // Burst of random bytes, leaning towards the extremes now and then
  task automatic send_burst(input int len);
    logic [7:0] b;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 7))
        0: b = 8'h00;
        1: b = 8'hFF;
        2: b = 8'h80;
        3: b = 8'h7F;
        default: b = 8'($urandom_range(0, 255));
      endcase
      send_byte(b, k == len - 1);
    end
    bursts_sent++;
  endtask

  // Drop valid, drain all outstanding fixes, then let the core settle
  task automatic settle();
    @(negedge clk);
    byte_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (32) @(posedge clk);
  endtask

  // Write all four calibration registers in back-to-back cycles
  task automatic set_cal(input logic [15:0] bx, input logic [15:0] by,
                         input logic [15:0] sx, input logic [15:0] sy);
    logic [15:0] vals [4];
    vals[REG_BIAS_X]  = bx;
    vals[REG_BIAS_Y]  = by;
    vals[REG_SCALE_X] = sx;
    vals[REG_SCALE_Y] = sy;
    for (int k = 0; k < 4; k++) begin
      @(negedge clk);
      cfg_write <= 1'b1;
      cfg_index <= 2'(k);
      cfg_data  <= vals[k];
    end
    @(negedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // Result side: hold stall for a random number of cycles per transaction
  initial begin
    int gap;
    result_stall = 1'b0;
    @(negedge clk iff !rst);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 5);
      repeat (gap) begin
        @(negedge clk);
        result_stall <= 1'b1;
      end
      @(negedge clk);
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  // Stimulus and verdict
  initial begin
    int len;
    int phase_start;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    byte_valid   = 1'b0;
    data_byte    = '0;
    end_of_burst = 1'b0;
    steady       = 1'b0;
    bytes_sent   = 0;
    bursts_sent  = 0;
    settings_used = 1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed bursts at reset calibration
    send_byte(8'hA5, 1'b1);           // lone end byte: stale zero sample
    bursts_sent++;
    send_six(48'h7FFF_1234_8000);     // largest X, largest negated Y
    send_six(48'h8000_FFFF_7FFF);     // most negative X, left lower half
    send_six(48'h8000_0000_FFFF);     // most negative X, Y just above zero
    for (int k = 0; k < 7; k++) send_byte(8'hFF, k == 6);  // long burst
    bursts_sent++;
    send_byte(8'h00, 1'b0);           // short burst
    send_byte(8'h80, 1'b1);
    bursts_sent++;
    settle();

    // Random bursts under several calibration settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        1: set_cal(16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        2: set_cal(16'h7FFF, 16'h8000, 16'h0000, 16'h0000);
        3: set_cal(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 32768)), 16'($urandom_range(0, 32768)));
        4: set_cal(16'h0000, 16'h0000, 16'h4000, 16'hFFFF);
        default: set_cal(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 145) begin
        if ($urandom_range(0, 7) == 0) steady = !steady;
        len = ($urandom_range(0, 4) != 0) ? 6 : $urandom_range(1, 9);
        send_burst(len);
      end
      settle();
    end

    $display("Sent %0d bursts (%0d bytes) under %0d calibration settings.",
             bursts_sent, bytes_sent, settings_used);
    $display("Checked %0d heading results, %0d failures.", checked, failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mch_pkg.sv
design/mch_ctrl.sv
design/mch_dp.sv
design/magnetometer_compass_heading_core.sv
sim/mch_heading_checker.sv
sim/tb.sv
